[hw/rtl/qspd_pkg.sv]
`timescale 1ns / 1ps

package qspd_pkg;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_INIT   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef logic [2:0] t_step;

    localparam t_step STEP_ZERO = 3'b000;
    localparam t_step STEP_P1   = 3'b001;
    localparam t_step STEP_P2   = 3'b010;
    localparam t_step STEP_ERR  = 3'b011;
    localparam t_step STEP_M2   = 3'b110;
    localparam t_step STEP_M1   = 3'b111;

    // Indexed by {older pins, recent pins, new pins}.
    localparam t_step STEP_TABLE [64] = '{
        STEP_ZERO, STEP_P1,   STEP_M1,   STEP_ERR,
        STEP_M1,   STEP_ZERO, STEP_P2,   STEP_P1,
        STEP_P1,   STEP_M2,   STEP_ZERO, STEP_M1,
        STEP_ERR,  STEP_M1,   STEP_P1,   STEP_ZERO,
        STEP_ZERO, STEP_P1,   STEP_M1,   STEP_M2,
        STEP_M1,   STEP_ZERO, STEP_ERR,  STEP_P1,
        STEP_P1,   STEP_ERR,  STEP_ZERO, STEP_M1,
        STEP_P2,   STEP_M1,   STEP_P1,   STEP_ZERO,
        STEP_ZERO, STEP_P1,   STEP_M1,   STEP_P2,
        STEP_M1,   STEP_ZERO, STEP_ERR,  STEP_P1,
        STEP_P1,   STEP_ERR,  STEP_ZERO, STEP_M1,
        STEP_M2,   STEP_M1,   STEP_P1,   STEP_ZERO,
        STEP_ZERO, STEP_P1,   STEP_M1,   STEP_ERR,
        STEP_M1,   STEP_ZERO, STEP_M2,   STEP_P1,
        STEP_P1,   STEP_P2,   STEP_ZERO, STEP_M1,
        STEP_ERR,  STEP_M1,   STEP_P1,   STEP_ZERO
    };

    localparam logic [15:0] RATIO_MAX       = 16'hFFFF;
    localparam logic [15:0] PROP_GAIN_RST   = 16'd5000;
    localparam logic [15:0] DERIV_GAIN_RST  = 16'd24000;
    localparam logic        REG_PROP_GAIN   = 1'b0;
    localparam logic        REG_DERIV_GAIN  = 1'b1;

endpackage

[hw/rtl/quadrature_servo_pd_axis.sv]
`timescale 1ns / 1ps

// Two-axis quadrature encoder counter with a proportional-derivative drive. Each item
// names an axis and a function: a pin sample steps the axis position through the
// transition table, an initialize item reloads the pin history and clears the stored
// error, and a control tick returns two inverted PWM ratios from the position error.
// One item is accepted every clock while the result side does not stall; the rate is set
// by the per-axis state being read and written in a single stage, with the two gain
// multiplies and the final add and saturation in the two stages after it. Backpressure
// on the result side stalls only the stages that are full.
module quadrature_servo_pd_axis
    import qspd_pkg::*;
#(
    parameter int POS_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pins[1:0], target[33:2], zero fill
    input  logic [2:0]  s_axis_tuser,   // func[1:0], axis[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // position[31:0], step[34:32], drive_first[50:35],
                                        // drive_second[66:51], zero fill
    output logic [1:0]  m_axis_tuser,   // illegal[0], drive_valid[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_prop_gain;
    logic [15:0] r_deriv_gain;

    logic [1:0]          r_older  [2];
    logic [1:0]          r_recent [2];
    logic [POS_BITS-1:0] r_count  [2];
    logic [31:0]         r_prior  [2];

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    t_func              r_s1_func;
    logic               r_s1_axis;
    logic [1:0]         r_s1_pins;
    logic [31:0]        r_s1_target;

    logic               r_s2_tick;
    logic [31:0]        r_s2_pos;
    t_step              r_s2_step;
    logic               r_s2_illegal;
    logic signed [31:0] r_s2_err;
    logic signed [32:0] r_s2_diff;

    logic               r_s3_tick;
    logic [31:0]        r_s3_pos;
    t_step              r_s3_step;
    logic               r_s3_illegal;
    logic signed [48:0] r_s3_prod_p;
    logic signed [49:0] r_s3_prod_d;

    logic        r_s4_drive_valid;
    logic        r_s4_illegal;
    logic [31:0] r_s4_pos;
    t_step       r_s4_step;
    logic [15:0] r_s4_first;
    logic [15:0] r_s4_second;

    logic                cfg_wr;
    logic                upd;
    logic [5:0]          idx;
    t_step               code;
    logic                is_err;
    logic [POS_BITS-1:0] cnt_cur;
    logic [POS_BITS-1:0] cnt_new;
    logic [1:0]          n_older;
    logic [1:0]          n_recent;
    logic [POS_BITS-1:0] n_count;
    logic [31:0]         n_prior;
    logic [31:0]         pos_cur;
    logic [31:0]         err_u;
    logic [31:0]         n_s2_pos;
    t_step               n_s2_step;
    logic                n_s2_illegal;
    logic signed [50:0]  drive;
    logic                drive_pos;
    logic [15:0]         n_first;
    logic [15:0]         n_second;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_DERIV_GAIN) ? {16'd0, r_deriv_gain}
                                                 : {16'd0, r_prop_gain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PROP_GAIN:  r_prop_gain  <= pwdata[15:0];
                REG_DERIV_GAIN: r_deriv_gain <= pwdata[15:0];
                default:        r_prop_gain  <= r_prop_gain;
            endcase
        end
    end

    // Stage handshake: a stage takes a new item when it is empty or its successor moves.
    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: input register.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_func   <= t_func'(s_axis_tuser[1:0]);
            r_s1_axis   <= s_axis_tuser[2];
            r_s1_pins   <= s_axis_tdata[1:0];
            r_s1_target <= s_axis_tdata[33:2];
        end
    end

    // Stage 2: per-axis state read and update.
    assign upd     = r_v1 && rdy2;
    assign idx     = {r_older[r_s1_axis], r_recent[r_s1_axis], r_s1_pins};
    assign code    = STEP_TABLE[idx];
    assign is_err  = (code == STEP_ERR);
    assign cnt_cur = r_count[r_s1_axis];
    assign cnt_new = cnt_cur + POS_BITS'($signed(code));
    assign pos_cur = 32'($signed(cnt_cur));
    assign err_u   = r_s1_target - pos_cur;

    always_comb begin
        n_older      = r_older[r_s1_axis];
        n_recent     = r_recent[r_s1_axis];
        n_count      = cnt_cur;
        n_prior      = r_prior[r_s1_axis];
        n_s2_step    = STEP_ZERO;
        n_s2_illegal = 1'b0;
        unique case (r_s1_func)
            FUNC_SAMPLE: begin
                n_older  = r_recent[r_s1_axis];
                n_recent = r_s1_pins;
                if (is_err) begin
                    n_s2_illegal = 1'b1;
                end else begin
                    n_count   = cnt_new;
                    n_s2_step = code;
                end
            end
            FUNC_TICK: begin
                n_prior = err_u;
            end
            FUNC_INIT: begin
                n_older  = r_s1_pins;
                n_recent = r_s1_pins;
                n_prior  = 32'd0;
            end
            FUNC_NONE: begin
                n_prior = r_prior[r_s1_axis];
            end
            default: begin
                n_prior = r_prior[r_s1_axis];
            end
        endcase
        n_s2_pos = 32'($signed(n_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 2; a++) begin
                r_older[a]  <= 2'd0;
                r_recent[a] <= 2'd0;
                r_count[a]  <= '0;
                r_prior[a]  <= 32'd0;
            end
        end else if (upd) begin
            r_older[r_s1_axis]  <= n_older;
            r_recent[r_s1_axis] <= n_recent;
            r_count[r_s1_axis]  <= n_count;
            r_prior[r_s1_axis]  <= n_prior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_tick    <= (r_s1_func == FUNC_TICK);
            r_s2_pos     <= n_s2_pos;
            r_s2_step    <= n_s2_step;
            r_s2_illegal <= n_s2_illegal;
            r_s2_err     <= $signed(err_u);
            r_s2_diff    <= 33'($signed(err_u)) - 33'($signed(r_prior[r_s1_axis]));
        end
    end

    // Stage 3: gain multiplies.
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_tick    <= r_s2_tick;
            r_s3_pos     <= r_s2_pos;
            r_s3_step    <= r_s2_step;
            r_s3_illegal <= r_s2_illegal;
            r_s3_prod_p  <= 49'($signed({1'b0, r_prop_gain})) * 49'(r_s2_err);
            r_s3_prod_d  <= 50'($signed({1'b0, r_deriv_gain})) * 50'(r_s2_diff);
        end
    end

    // Stage 4: sum, saturate to the two ratios, output register.
    assign drive     = 51'(r_s3_prod_p) + 51'(r_s3_prod_d);
    assign drive_pos = (drive > 51'sd0);

    always_comb begin
        n_first  = 16'd0;
        n_second = 16'd0;
        if (r_s3_tick) begin
            if (drive_pos) begin
                n_first  = (drive > 51'sd65535) ? 16'd0 : RATIO_MAX - drive[15:0];
                n_second = RATIO_MAX;
            end else begin
                n_first  = RATIO_MAX;
                n_second = (drive < -51'sd65535) ? 16'd0 : RATIO_MAX + drive[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_drive_valid <= r_s3_tick;
            r_s4_illegal     <= r_s3_illegal;
            r_s4_pos         <= r_s3_pos;
            r_s4_step        <= r_s3_step;
            r_s4_first       <= n_first;
            r_s4_second      <= n_second;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {5'd0, r_s4_second, r_s4_first, r_s4_step, r_s4_pos};
    assign m_axis_tuser  = {r_s4_drive_valid, r_s4_illegal};

endmodule
